FILE: rtl/mrl_pkg.sv
package mrl_pkg;

    // Bucket fixed point: one token is 1 << FRAC_BITS
    localparam int FRAC_BITS = 8;
    // Timestamps wrap modulo 2^TIME_BITS (at most the 32-bit port width)
    localparam int TIME_BITS = 32;

    localparam int NOW_W   = 32;
    localparam int RATE_W  = 20;
    localparam int COUNT_W = 16;
    localparam int VERD_W  = 2;

    // Refill gain is elapsed * rate >> REFILL_SHIFT; elapsed >= 2^REFILL_SHIFT fills
    localparam int REFILL_SHIFT = 3;
    localparam int PROD_W       = RATE_W + REFILL_SHIFT;

    localparam logic [RATE_W-1:0] ONE_TOKEN    = RATE_W'(1) << FRAC_BITS;
    localparam logic [RATE_W-1:0] INIT_ALLOW_RST = RATE_W'(1280);

    // Queue depth for the command queue and the result queue
    localparam int QDEPTH = 2;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_RATE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START  = 2'd3;

    localparam logic [VERD_W-1:0] VERDICT_ALLOW = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_FLOOD = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_KICK  = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_limit;
        logic [COUNT_W-1:0] kick_threshold;
        logic [RATE_W-1:0]  initial_allowance;
        logic [NOW_W-1:0]   start_seconds;
    } t_cfg;

    // Classified request handed from front to back
    typedef struct packed {
        logic                    first;
        logic                    fill;
        logic [REFILL_SHIFT-1:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic [VERD_W-1:0]  verdict;
        logic [COUNT_W-1:0] flood_count;
    } t_res;

endpackage

FILE: rtl/message_rate_limiter_top.sv
// Token-bucket policer for message requests.
//
// Request channel (queue style): drive i_now_seconds and push; the request
// transaction is taken at a rising edge with push high and full low.
// Result channel (queue style): while empty is low, o_verdict and
// o_flood_count show the oldest result; pop with empty low takes it.
// One result per request, in request order.
// Verdict: 0 allowed, 1 flooding rejected, 2 kick.
//
// Requests enter the command queue; the bucket update (3-bit by 20-bit
// multiply, add, cap, compare) on its head is combinational, registered
// into the result queue. One request per cycle while results are popped.
// A two-entry command queue and a two-entry result queue sit between
// the parts, so a stalled receiver backs up into full only once both fill.
//
// Reset (synchronous, i_rst_n low): queues empty, bucket unprimed, config
// to defaults. The user writes configuration over the APB port (byte
// address 4*index) only while no transaction is in flight; not enforced.
module message_rate_limiter_top import mrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               push,
    output logic               full,
    input  logic [NOW_W-1:0]   i_now_seconds,
    // result channel
    output logic               empty,
    input  logic               pop,
    output logic [VERD_W-1:0]  o_verdict,
    output logic [COUNT_W-1:0] o_flood_count,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    // register block
    mrl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front: takes requests, tracks time, computes elapsed class
    mrl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_now_seconds (i_now_seconds),
        .i_cfg         (cfg),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    // back: bucket arithmetic, flood counter, result queue
    mrl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .empty         (empty),
        .pop           (pop),
        .o_verdict     (o_verdict),
        .o_flood_count (o_flood_count)
    );

endmodule

FILE: rtl/mrl_regs.sv
module mrl_regs import mrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[REG_IDX_W+1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_limit        <= '0;
            r_cfg.kick_threshold    <= '0;
            r_cfg.initial_allowance <= INIT_ALLOW_RST;
            r_cfg.start_seconds     <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_RATE:   r_cfg.rate_limit        <= pwdata[RATE_W-1:0];
                REG_THRESH: r_cfg.kick_threshold    <= pwdata[COUNT_W-1:0];
                REG_INIT:   r_cfg.initial_allowance <= pwdata[RATE_W-1:0];
                REG_START:  r_cfg.start_seconds     <= pwdata[NOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RATE:   prdata = PDATA_W'(r_cfg.rate_limit);
            REG_THRESH: prdata = PDATA_W'(r_cfg.kick_threshold);
            REG_INIT:   prdata = PDATA_W'(r_cfg.initial_allowance);
            REG_START:  prdata = PDATA_W'(r_cfg.start_seconds);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/mrl_front.sv
module mrl_front import mrl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [NOW_W-1:0] i_now_seconds,
    input  t_cfg             i_cfg,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_take
);

    logic                 r_primed;
    logic [TIME_BITS-1:0] r_last;
    t_cmd                 r_q [QDEPTH];
    logic [QA_W-1:0]      r_wptr;
    logic [QA_W-1:0]      r_rptr;
    logic [QCNT_W-1:0]    r_cnt;
    logic [QCNT_W-1:0]    n_cnt;

    logic                 accept;
    logic                 take;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] prev;
    logic [TIME_BITS-1:0] elapsed;
    t_cmd                 cmd_in;

    assign full        = (r_cnt == QCNT_W'(QDEPTH));
    assign accept      = push & ~full;
    assign o_cmd_valid = (r_cnt != '0);
    assign take        = i_cmd_take & o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    // first request measures from the configured start time
    assign now_t   = i_now_seconds[TIME_BITS-1:0];
    assign prev    = r_primed ? r_last : i_cfg.start_seconds[TIME_BITS-1:0];
    assign elapsed = now_t - prev;

    always_comb begin
        cmd_in.first   = ~r_primed;
        cmd_in.fill    = |elapsed[TIME_BITS-1:REFILL_SHIFT];
        cmd_in.elapsed = elapsed[REFILL_SHIFT-1:0];
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!accept && take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_last   <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_primed <= 1'b1;
                r_last   <= now_t;
                r_wptr   <= (r_wptr == QA_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (take) begin
                r_rptr <= (r_rptr == QA_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("command queue overfilled");

    a_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_primed)
        else $error("primed not set after first transaction");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_last == $past(now_t)))
        else $error("last timestamp not updated");

endmodule

FILE: rtl/mrl_back.sv
module mrl_back import mrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_take,
    output logic               empty,
    input  logic               pop,
    output logic [VERD_W-1:0]  o_verdict,
    output logic [COUNT_W-1:0] o_flood_count
);

    logic [RATE_W-1:0]  r_allowance;
    logic [COUNT_W-1:0] r_flood;
    t_res               r_q [QDEPTH];
    logic [QA_W-1:0]    r_wptr;
    logic [QA_W-1:0]    r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;
    logic [RATE_W-1:0]  n_allowance;
    logic [COUNT_W-1:0] n_flood;

    logic               take;
    logic               deq;
    logic [RATE_W-1:0]  base;
    logic [PROD_W-1:0]  prod;
    logic [RATE_W-1:0]  gain;
    logic [RATE_W:0]    sum;
    logic [RATE_W-1:0]  bucket;
    t_res               res;

    assign deq        = pop & ~empty;
    assign empty      = (r_cnt == '0);
    assign o_cmd_take = i_cmd_valid & ((r_cnt != QCNT_W'(QDEPTH)) | deq);
    assign take       = o_cmd_take;

    assign o_verdict     = r_q[r_rptr].verdict;
    assign o_flood_count = r_q[r_rptr].flood_count;

    // bucket refill and spend
    assign base = i_cmd.first ? i_cfg.initial_allowance : r_allowance;
    assign prod = PROD_W'(i_cmd.elapsed) * PROD_W'(i_cfg.rate_limit);
    assign gain = prod[PROD_W-1:REFILL_SHIFT];
    assign sum  = {1'b0, base} + {1'b0, gain};

    always_comb begin
        if (i_cmd.fill || (sum > {1'b0, i_cfg.rate_limit})) begin
            bucket = i_cfg.rate_limit;
        end else begin
            bucket = sum[RATE_W-1:0];
        end
    end

    always_comb begin
        n_allowance = base;
        n_flood     = r_flood;
        res.verdict = VERDICT_ALLOW;
        if (i_cfg.rate_limit != '0) begin
            if (bucket < ONE_TOKEN) begin
                n_allowance = bucket;
                n_flood     = (r_flood == '1) ? r_flood : r_flood + 1'b1;
                res.verdict = (n_flood > i_cfg.kick_threshold) ? VERDICT_KICK
                                                               : VERDICT_FLOOD;
            end else begin
                n_allowance = bucket - ONE_TOKEN;
                n_flood     = '0;
            end
        end
        res.flood_count = n_flood;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (take && !deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!take && deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowance <= '0;
            r_flood     <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_cnt       <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (take) begin
                r_allowance <= n_allowance;
                r_flood     <= n_flood;
                r_wptr      <= (r_wptr == QA_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (deq) begin
                r_rptr <= (r_rptr == QA_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wptr] <= res;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_reject_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && res.verdict != VERDICT_ALLOW) |=> (r_flood != '0))
        else $error("rejected transaction left flood counter at zero");

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrl_pkg::*;

    // ------------------------------------------------------------------
    // DUT ports, all at a known level; after time zero all inputs but the
    // clock change only with nonblocking assignments at the rising edge.
    // ------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               push          = 1'b0;
    logic               full;
    logic [NOW_W-1:0]   i_now_seconds = '0;
    logic               empty;
    logic               pop           = 1'b0;
    logic [VERD_W-1:0]  o_verdict;
    logic [COUNT_W-1:0] o_flood_count;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    message_rate_limiter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_now_seconds (i_now_seconds),
        .empty         (empty),
        .pop           (pop),
        .o_verdict     (o_verdict),
        .o_flood_count (o_flood_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Policer shadow: configuration registers and bucket state as the
    // block should hold them. Updated on every accepted request and on
    // every register write.
    // ------------------------------------------------------------------
    logic [RATE_W-1:0]  shadow_rate;
    logic [COUNT_W-1:0] shadow_thresh;
    logic [RATE_W-1:0]  shadow_init;
    logic [NOW_W-1:0]   shadow_start;
    logic               shadow_primed;
    logic [NOW_W-1:0]   shadow_last;
    logic [RATE_W-1:0]  shadow_allow;
    logic [COUNT_W-1:0] shadow_flood;

    initial begin
        shadow_rate   = '0;
        shadow_thresh = '0;
        shadow_init   = INIT_ALLOW_RST;
        shadow_start  = '0;
        shadow_primed = 1'b0;
        shadow_last   = '0;
        shadow_allow  = '0;
        shadow_flood  = '0;
    end

    // Requests waiting to be pushed, and verdicts waiting to come out.
    logic [NOW_W-1:0] request_q[$];
    t_res             verdict_q[$];

    // Set by the sequencer for stretches that run without any idling.
    bit          quiet = 1'b0;

    int unsigned sent_cnt    = 0;
    int unsigned rcvd_cnt    = 0;
    int unsigned bad_cnt     = 0;
    int unsigned n_settings  = 0;
    int unsigned n_allow     = 0;
    int unsigned n_flood     = 0;
    int unsigned n_kick      = 0;
    int unsigned peak_flood  = 0;

    // Work out the verdict of one request and queue it.
    task automatic police_request(input logic [NOW_W-1:0] now);
        logic [NOW_W-1:0]  elapsed;
        logic [PROD_W:0]   bucket;
        t_res              res;
        if (!shadow_primed) begin
            // first request after reset picks up the start registers
            shadow_last   = shadow_start;
            shadow_allow  = shadow_init;
            shadow_primed = 1'b1;
        end
        elapsed     = now - shadow_last;    // wraps modulo 2^32
        shadow_last = now;
        res.verdict = VERDICT_ALLOW;
        if (shadow_rate != '0) begin
            if (elapsed >= (1 << REFILL_SHIFT))
                bucket = (PROD_W+1)'(shadow_rate);
            else
                bucket = (PROD_W+1)'(shadow_allow)
                       + (((PROD_W+1)'(elapsed[REFILL_SHIFT-1:0]) * shadow_rate)
                          >> REFILL_SHIFT);
            if (bucket > shadow_rate)
                bucket = (PROD_W+1)'(shadow_rate);
            if (bucket < ONE_TOKEN) begin
                shadow_allow = bucket[RATE_W-1:0];
                if (shadow_flood != '1)
                    shadow_flood = shadow_flood + 1'b1;
                res.verdict = (shadow_flood > shadow_thresh) ? VERDICT_KICK
                                                             : VERDICT_FLOOD;
            end else begin
                shadow_flood = '0;
                shadow_allow = bucket[RATE_W-1:0] - ONE_TOKEN;
            end
        end
        res.flood_count = shadow_flood;
        verdict_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Request driver. The request on the port is always request_q[0]; it
    // is dropped from the queue at the edge where the transaction is
    // taken. A held request stays put while full is high; between
    // requests the driver may idle, unless quiet is set.
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            send_gap <= 0;
        end else begin
            if (push && !full) begin
                police_request(request_q.pop_front());
                sent_cnt++;
            end
            if (push && full) begin
                // not taken yet: keep request and push as they are
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                push     <= 1'b0;
            end else if (request_q.size() != 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 15);
                    push     <= 1'b0;
                end else begin
                    push          <= 1'b1;
                    i_now_seconds <= request_q[0];
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every result transaction is checked against the
    // oldest queued verdict; pop backs off in random bursts as well.
    // ------------------------------------------------------------------
    int unsigned recv_gap = 0;
    t_res        want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (pop && !empty) begin
                rcvd_cnt++;
                if (verdict_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("[%0t] result %0d with nothing pending: verdict %0d count %0d",
                                 $realtime, rcvd_cnt, o_verdict, o_flood_count);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_verdict !== want.verdict || o_flood_count !== want.flood_count) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display({"[%0t] result %0d: expected verdict %0d count %0d,",
                                      " got verdict %0d count %0d"},
                                     $realtime, rcvd_cnt, want.verdict, want.flood_count,
                                     o_verdict, o_flood_count);
                    end
                end
                case (o_verdict)
                    VERDICT_ALLOW: n_allow++;
                    VERDICT_FLOOD: n_flood++;
                    VERDICT_KICK:  n_kick++;
                    default: ;
                endcase
                if (o_flood_count > peak_flood)
                    peak_flood = 32'(o_flood_count);
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                pop      <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 15);
                pop      <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration: setup cycle, then access cycle; the register takes
    // the value at the edge with psel, penable, pwrite and pready high.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RATE:   shadow_rate   = value[RATE_W-1:0];
            REG_THRESH: shadow_thresh = value[COUNT_W-1:0];
            REG_INIT:   shadow_init   = value[RATE_W-1:0];
            REG_START:  shadow_start  = value[NOW_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper bits of the narrow registers carry junk; the block must mask.
    task automatic set_config(input logic [PDATA_W-1:0] rate,
                              input logic [PDATA_W-1:0] thresh,
                              input logic [PDATA_W-1:0] init,
                              input logic [PDATA_W-1:0] start);
        write_reg(REG_RATE,   rate);
        write_reg(REG_THRESH, thresh);
        write_reg(REG_INIT,   init);
        write_reg(REG_START,  start);
        n_settings++;
    endtask

    // Let every queued request through and every verdict out, then let
    // the pipeline settle before anything is reconfigured.
    task automatic drain();
        while (request_q.size() != 0 || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Random phase: fresh register values, then mostly a believable stream
    // of timestamps (small steps around the refill window) with some jumps
    // and steps backwards mixed in.
    task automatic random_phase(input int unsigned n_items);
        logic [PDATA_W-1:0] rate;
        logic [PDATA_W-1:0] thresh;
        logic [NOW_W-1:0]   ts;
        case ($urandom_range(0, 6))
            0:       rate = 0;
            1:       rate = 32'h000F_FFFF;
            2:       rate = PDATA_W'(ONE_TOKEN);
            3:       rate = $urandom_range(1, 255);
            4, 5:    rate = $urandom_range(256, 2048);
            default: rate = $urandom & 32'h000F_FFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       thresh = 0;
            1:       thresh = 32'h0000_FFFF;
            default: thresh = $urandom_range(0, 6);
        endcase
        rate[PDATA_W-1:RATE_W]    = $urandom;
        thresh[PDATA_W-1:COUNT_W] = $urandom;
        set_config(rate, thresh, $urandom, $urandom);
        ts = $urandom;
        @(negedge i_clk);
        repeat (n_items) begin
            case ($urandom_range(0, 15))
                0:       ts = $urandom;
                1:       ts = ts - $urandom_range(1, 3);
                2, 3:    ts = ts + $urandom_range(8, 20);
                default: ts = ts + $urandom_range(0, 3);
            endcase
            request_q.push_back(ts);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Three tokens of cap, kick above two floods; the
        // initial fill is far above the cap and the start time sits just
        // below the wrap, so the first request refills across it.
        set_config(32'hABC0_0300, 32'hFFFF_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        @(negedge i_clk);
        // same-second burst drains the bucket into flood and kick, then
        // partial refill, full refill, backwards step and wrap
        request_q = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
                      32'd2, 32'd5, 32'd13, 32'd0, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        drain();

        // limiting off: always allowed, count left as it stood
        set_config(32'h0000_0000, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000);
        @(negedge i_clk);
        request_q = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555};
        drain();

        // full-scale rate, zero threshold
        set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h000F_FFFF, 32'hFFFF_FFFF);
        @(negedge i_clk);
        request_q = '{32'h0000_0000, 32'h0000_0000};
        drain();

        // Sub-token rate: the bucket never reaches one token, so every
        // request is rejected and the count climbs past the threshold
        // into kick.
        set_config(32'h0000_0001, 32'hFFFF_0014, 32'h0000_0000, 32'h0000_0000);
        @(negedge i_clk);
        repeat (40) request_q.push_back($urandom);
        drain();

        // Random part: several settings, one of them without any idling,
        // and the last one quiet as well.
        for (int p = 0; p < 6; p++) begin
            quiet = (p == 2) || (p == 5);
            random_phase(80);
        end

        $display("Covered %0d requests over %0d register settings: limiting off,",
                 sent_cnt, n_settings);
        $display("sub-token, one-token and full-scale rates, time wrap and kick.");
        $display("Verdicts %0d allow, %0d flood, %0d kick, peak count %0d.",
                 n_allow, n_flood, n_kick, peak_flood);
        if (bad_cnt == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d bad results, %0d verdicts never seen", bad_cnt, verdict_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, sized for the slowest legal run several times over.
    initial begin
        #100_000_000;
        $display("Timeout: %0d requests sent, %0d results received", sent_cnt, rcvd_cnt);
        $display("Test completed with failures");
        $finish;
    end

endmodule
